/* rtl/wfsa_pkg.sv */
// ----------------------------------------------------------------------------
// wfsa_pkg: shared definitions for the worst-fit segment allocator
// Table geometry, request and status codes, the table entry layout and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wfsa_pkg;

  localparam int MaxSegments = 64;
  localparam int AddrBits    = 32;
  localparam int OwnerW      = 16;
  localparam int FuncW       = 2;
  localparam int StatusW     = 3;
  localparam int EntryIdxW   = 6;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = $clog2(MaxSegments + 1);

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef enum logic [StatusW-1:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_FREED     = 3'd1,
    STAT_NO_SPACE  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_READ      = 3'd4
  } status_t;

  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic [AddrBits-1:0] len;
    logic [OwnerW-1:0]   owner;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Commands from the sequencer to the gap unit.
  typedef struct packed {
    logic clr;
    logic take;
    logic first;
  } gap_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_TAIL,
    ST_PLACE,
    ST_SHIFT_UP,
    ST_SHIFT_UP_END,
    ST_INSERT,
    ST_FIND,
    ST_SHIFT_DN,
    ST_SHIFT_DN_END,
    ST_RELEASE,
    ST_RD,
    ST_RD_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/wfsa_ram.sv */
// ----------------------------------------------------------------------------
// wfsa_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/wfsa_gap_unit.sv */
// ----------------------------------------------------------------------------
// wfsa_gap_unit: shared gap subtract and compare unit
// Takes one candidate per cycle while take is set, measures the gap from the
// previous segment end and keeps the first strictly largest gap with its position and base.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsa_gap_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wfsa_pkg::gap_ctrl_t           ctrl,
  input  wire logic [wfsa_pkg::AddrBits-1:0] cand_addr,
  input  wire logic [wfsa_pkg::AddrBits-1:0] cand_end,
  input  wire logic [wfsa_pkg::CntW-1:0]     cand_pos,
  output logic      [wfsa_pkg::AddrBits-1:0] best_gap,
  output logic      [wfsa_pkg::CntW-1:0]     best_pos,
  output logic      [wfsa_pkg::AddrBits-1:0] best_base
);

  import wfsa_pkg::*;

  logic [AddrBits-1:0] prev_end_r;
  logic [AddrBits-1:0] best_r;
  logic [CntW-1:0]     pos_r;
  logic [AddrBits-1:0] base_r;
  logic [AddrBits:0]   diff;
  logic [AddrBits-1:0] gap;
  logic                better;

  // A candidate that starts at or before the previous end leaves no gap.
  always_comb begin
    diff   = {1'b0, cand_addr} - {1'b0, prev_end_r};
    gap    = diff[AddrBits] ? '0 : diff[AddrBits-1:0];
    better = gap > best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      best_r <= '0;
      pos_r  <= '0;
    end else if (ctrl.take && !ctrl.first && better) begin
      best_r <= gap;
      pos_r  <= cand_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      prev_end_r <= cand_end;
      if (!ctrl.first && better) begin
        base_r <= prev_end_r;
      end
    end
  end

  assign best_gap  = best_r;
  assign best_pos  = pos_r;
  assign best_base = base_r;

endmodule

`default_nettype wire

/* rtl/worst_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// worst_fit_segment_allocator: worst-fit segment table with allocate and free
// Keeps an address-ordered table of segments in a RAM and serves allocate,
// free-by-owner and read-entry requests with one shared gap unit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  in_func, in_req_size,
//                                             in_owner_id, in_entry_index
//   out_      output     out_valid/out_stall  out_status, out_seg_address,
//                                             out_seg_length, out_seg_owner,
//                                             out_entry_valid, out_space_left
//   cfg_      input      cfg_wr_en            cfg_wr_data (capacity)
//
// One request is worked on at a time; in_stall is high from acceptance until
// its result has moved into the output register. An allocate makes one pass
// over the table RAM through the gap unit, then one RAM read and write per
// moved entry; a free searches the table, then moves the later entries down.
// The single read port of the table RAM paces these steps.
// Reset empties the table, sets the capacity to all ones and the owner id
// counter to zero; the RAM itself is not cleared, because entries at or above
// the segment count are never used. A stalled output register holds its
// result and the next request is still accepted; it waits at its end until
// the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_segment_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Request channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [wfsa_pkg::FuncW-1:0]     in_func,
  input  wire logic [wfsa_pkg::AddrBits-1:0]  in_req_size,
  input  wire logic [wfsa_pkg::OwnerW-1:0]    in_owner_id,
  input  wire logic [wfsa_pkg::EntryIdxW-1:0] in_entry_index,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [wfsa_pkg::StatusW-1:0]   out_status,
  output logic      [wfsa_pkg::AddrBits-1:0]  out_seg_address,
  output logic      [wfsa_pkg::AddrBits-1:0]  out_seg_length,
  output logic      [wfsa_pkg::OwnerW-1:0]    out_seg_owner,
  output logic                                out_entry_valid,
  output logic      [wfsa_pkg::AddrBits-1:0]  out_space_left,
  // Capacity register.
  input  wire logic                           cfg_wr_en,
  input  wire logic [wfsa_pkg::AddrBits-1:0]  cfg_wr_data
);

  import wfsa_pkg::*;

  localparam int CmpW = (CntW > EntryIdxW) ? CntW : EntryIdxW;

  // Sequencer state.
  state_t state_r, state_nxt;

  // Architectural state.
  logic [AddrBits-1:0] capacity_r, capacity_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic [AddrBits-1:0] free_r, free_nxt;
  logic [OwnerW-1:0]   id_r, id_nxt;

  // Latched request.
  func_t                func_r, func_nxt;
  logic [AddrBits-1:0]  size_r, size_nxt;
  logic [OwnerW-1:0]    oid_r, oid_nxt;
  logic [EntryIdxW-1:0] idx_r, idx_nxt;

  // Table walk: read pointer, move pointer and the read pipeline tags.
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic [CntW-1:0] src_r, src_nxt;
  logic            scan_vld_r, scan_vld_nxt;
  logic [CntW-1:0] scan_idx_r, scan_idx_nxt;
  logic            wb_vld_r, wb_vld_nxt;
  logic [IdxW-1:0] wb_addr_r, wb_addr_nxt;

  // Pending result and output register.
  status_t             res_status_r, res_status_nxt;
  logic [AddrBits-1:0] res_addr_r, res_addr_nxt;
  logic [AddrBits-1:0] res_len_r, res_len_nxt;
  logic [OwnerW-1:0]   res_owner_r, res_owner_nxt;
  logic                res_valid_r, res_valid_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [AddrBits-1:0] out_addr_r, out_addr_nxt;
  logic [AddrBits-1:0] out_len_r, out_len_nxt;
  logic [OwnerW-1:0]   out_owner_r, out_owner_nxt;
  logic                out_evalid_r, out_evalid_nxt;
  logic [AddrBits-1:0] out_space_r, out_space_nxt;

  // Table RAM ports.
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;

  // Gap unit ports.
  gap_ctrl_t           gap_ctrl;
  logic [AddrBits-1:0] cand_addr;
  logic [AddrBits-1:0] cand_end;
  logic [CntW-1:0]     cand_pos;
  logic [AddrBits-1:0] best_gap;
  logic [CntW-1:0]     best_pos;
  logic [AddrBits-1:0] best_base;

  // Decode.
  logic            accept;
  logic            out_free;
  logic [CntW-1:0] cnt_last;
  logic [OwnerW-1:0] id_inc;
  logic            alloc_empty_ok;
  logic            alloc_scan;
  logic            place_ok;
  logic            owner_hit;
  logic            scan_last;
  logic            issue;
  logic            idx_in_range;
  entry_t          new_entry;

  wfsa_ram #(
    .Width (EntryW),
    .Depth (MaxSegments)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wfsa_gap_unit u_gap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (gap_ctrl),
    .cand_addr (cand_addr),
    .cand_end  (cand_end),
    .cand_pos  (cand_pos),
    .best_gap  (best_gap),
    .best_pos  (best_pos),
    .best_base (best_base)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_last = count_r - CntW'(1);
  assign id_inc   = id_r + OwnerW'(1);

  // An empty table takes the segment at address zero when it fits at all;
  // otherwise the table is walked, unless the request fails up front.
  assign alloc_empty_ok = (func_r == FUNC_ALLOC) && (size_r != '0) &&
                          (count_r == '0) && (size_r <= capacity_r);
  assign alloc_scan     = (func_r == FUNC_ALLOC) && (size_r != '0) &&
                          (count_r != '0) && (count_r != CntW'(MaxSegments)) &&
                          (size_r <= free_r);
  assign place_ok       = (best_pos != '0) && (size_r <= best_gap);

  assign owner_hit    = scan_vld_r && (rd_data.owner == oid_r);
  assign scan_last    = scan_vld_r && (scan_idx_r == cnt_last);
  assign idx_in_range = CmpW'(idx_r) < CmpW'(count_r);

  // The gap to the capacity limit is measured by the same unit at the end.
  assign cand_addr = (state_r == ST_TAIL) ? capacity_r : rd_data.addr;
  assign cand_end  = rd_data.addr + rd_data.len;
  assign cand_pos  = (state_r == ST_TAIL) ? count_r : scan_idx_r;

  always_comb begin
    new_entry.addr  = (state_r == ST_DECIDE) ? '0 : best_base;
    new_entry.len   = size_r;
    new_entry.owner = id_inc;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (func_r)
          FUNC_ALLOC: state_nxt = alloc_scan ? ST_SCAN : ST_OUT;
          FUNC_FREE:  state_nxt = (count_r == '0) ? ST_OUT : ST_FIND;
          FUNC_READ:  state_nxt = ST_RD;
          default:    state_nxt = ST_OUT;
        endcase
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: state_nxt = ST_PLACE;
      ST_PLACE: begin
        if (!place_ok) begin
          state_nxt = ST_OUT;
        end else if (best_pos == count_r) begin
          state_nxt = ST_INSERT;
        end else begin
          state_nxt = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_UP: begin
        if (src_r == best_pos) begin
          state_nxt = ST_SHIFT_UP_END;
        end
      end
      ST_SHIFT_UP_END: state_nxt = ST_INSERT;
      ST_INSERT:       state_nxt = ST_OUT;
      ST_FIND: begin
        if (owner_hit) begin
          state_nxt = (scan_idx_r == cnt_last) ? ST_RELEASE : ST_SHIFT_DN;
        end else if (scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SHIFT_DN: begin
        if (src_r == cnt_last) begin
          state_nxt = ST_SHIFT_DN_END;
        end
      end
      ST_SHIFT_DN_END: state_nxt = ST_RELEASE;
      ST_RELEASE:      state_nxt = ST_OUT;
      ST_RD:           state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:      state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Table RAM and gap unit control.
  always_comb begin
    gap_ctrl = '0;
    rd_addr  = src_r[IdxW-1:0];
    issue    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wb_addr_r;
    wr_data  = rd_data;
    case (state_r)
      ST_DECIDE: begin
        gap_ctrl.clr = 1'b1;
        if (alloc_empty_ok) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = new_entry;
        end
      end
      ST_SCAN: begin
        gap_ctrl.take  = scan_vld_r;
        gap_ctrl.first = (scan_idx_r == '0);
        rd_addr        = ptr_r[IdxW-1:0];
        issue          = ptr_r < count_r;
      end
      ST_TAIL: begin
        gap_ctrl.take = 1'b1;
      end
      ST_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = best_pos[IdxW-1:0];
        wr_data = new_entry;
      end
      ST_FIND: begin
        rd_addr = ptr_r[IdxW-1:0];
        issue   = (ptr_r < count_r) && !owner_hit;
      end
      ST_RD: begin
        rd_addr = IdxW'(idx_r);
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    // The entry read in the previous move cycle lands one slot over.
    if (wb_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = rd_data;
    end
  end

  // Datapath next values.
  always_comb begin
    capacity_nxt   = capacity_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    id_nxt         = id_r;
    func_nxt       = func_r;
    size_nxt       = size_r;
    oid_nxt        = oid_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    src_nxt        = src_r;
    scan_vld_nxt   = issue;
    scan_idx_nxt   = ptr_r;
    wb_vld_nxt     = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_len_nxt    = res_len_r;
    res_owner_nxt  = res_owner_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_len_nxt    = out_len_r;
    out_owner_nxt  = out_owner_r;
    out_evalid_nxt = out_evalid_r;
    out_space_nxt  = out_space_r;

    if (issue) begin
      ptr_nxt = ptr_r + CntW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt = func_t'(in_func);
          size_nxt = in_req_size;
          oid_nxt  = in_owner_id;
          idx_nxt  = in_entry_index;
        end
      end
      ST_DECIDE: begin
        ptr_nxt       = '0;
        res_addr_nxt  = '0;
        res_len_nxt   = '0;
        res_owner_nxt = '0;
        res_valid_nxt = 1'b0;
        case (func_r)
          FUNC_ALLOC: res_status_nxt = STAT_NO_SPACE;
          FUNC_FREE:  res_status_nxt = STAT_NOT_FOUND;
          default:    res_status_nxt = STAT_READ;
        endcase
        if (alloc_empty_ok) begin
          count_nxt      = CntW'(1);
          free_nxt       = free_r - size_r;
          id_nxt         = id_inc;
          res_status_nxt = STAT_ALLOCATED;
          res_len_nxt    = size_r;
          res_owner_nxt  = id_inc;
        end
      end
      ST_PLACE: begin
        src_nxt = cnt_last;
      end
      ST_SHIFT_UP: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = IdxW'(src_r + CntW'(1));
        if (src_r != best_pos) begin
          src_nxt = src_r - CntW'(1);
        end
      end
      ST_INSERT: begin
        count_nxt      = count_r + CntW'(1);
        free_nxt       = free_r - size_r;
        id_nxt         = id_inc;
        res_status_nxt = STAT_ALLOCATED;
        res_addr_nxt   = best_base;
        res_len_nxt    = size_r;
        res_owner_nxt  = id_inc;
      end
      ST_FIND: begin
        if (owner_hit) begin
          res_len_nxt   = rd_data.len;
          res_owner_nxt = rd_data.owner;
          src_nxt       = scan_idx_r + CntW'(1);
        end
      end
      ST_SHIFT_DN: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = IdxW'(src_r - CntW'(1));
        if (src_r != cnt_last) begin
          src_nxt = src_r + CntW'(1);
        end
      end
      ST_RELEASE: begin
        count_nxt      = cnt_last;
        free_nxt       = free_r + res_len_r;
        res_status_nxt = STAT_FREED;
      end
      ST_RD_WAIT: begin
        if (idx_in_range) begin
          res_valid_nxt = 1'b1;
          res_addr_nxt  = rd_data.addr;
          res_len_nxt   = rd_data.len;
          res_owner_nxt = rd_data.owner;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_len_nxt    = res_len_r;
          out_owner_nxt  = res_owner_r;
          out_evalid_nxt = res_valid_r;
          out_space_nxt  = free_r;
        end
      end
      default: begin
        wb_vld_nxt = 1'b0;
      end
    endcase

    // A capacity write starts the allocator over with an empty table.
    if (cfg_wr_en) begin
      capacity_nxt = cfg_wr_data;
      count_nxt    = '0;
      free_nxt     = cfg_wr_data;
      id_nxt       = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= '1;
      count_r     <= '0;
      free_r      <= '1;
      id_r        <= '0;
      scan_vld_r  <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      id_r        <= id_nxt;
      scan_vld_r  <= scan_vld_nxt;
      wb_vld_r    <= wb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    size_r       <= size_nxt;
    oid_r        <= oid_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    src_r        <= src_nxt;
    scan_idx_r   <= scan_idx_nxt;
    wb_addr_r    <= wb_addr_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_len_r    <= res_len_nxt;
    res_owner_r  <= res_owner_nxt;
    res_valid_r  <= res_valid_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_len_r    <= out_len_nxt;
    out_owner_r  <= out_owner_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_space_r  <= out_space_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_seg_address = out_addr_r;
  assign out_seg_length  = out_len_r;
  assign out_seg_owner   = out_owner_r;
  assign out_entry_valid = out_evalid_r;
  assign out_space_left  = out_space_r;

endmodule

`default_nettype wire
